// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define BBA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BBA_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/bba_pkg.sv -----
// shared types and constants of the buddy block allocator
`default_nettype none
package bba_pkg;

   // field widths
   localparam int FUNC_W    = 2;
   localparam int REQ_W     = 22;
   localparam int OFF_W     = 22;
   localparam int STAT_W    = 3;
   localparam int LVL_OUT_W = 4;
   localparam int CFG_W     = 4;
   localparam int NEED_W    = REQ_W + 1;

   // function codes of a request beat
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

   // status codes of a response beat
   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_MEMORY  = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_ALLOC  = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_OFFSET = 3'd4;

   // command codes between front and back
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;
   localparam logic [1:0] CMD_DONE  = 2'd3;

   // register map
   localparam logic REG_MIN_LOG2 = 1'b0;
   localparam logic REG_LEVELS   = 1'b1;

   // register limits and reset values
   localparam logic [CFG_W-1:0] MIN_LOG2_LO  = 4'd4;
   localparam logic [CFG_W-1:0] MIN_LOG2_HI  = 4'd12;
   localparam logic [CFG_W-1:0] MIN_LOG2_RST = 4'd5;
   localparam logic [CFG_W-1:0] LEVELS_RST   = 4'd11;

   // control part of a queued command
   typedef struct packed {
      logic [1:0]        op;
      logic [STAT_W-1:0] status;
   } cmd_ctl_type;

endpackage
`default_nettype wire

// ----- sv/bba_ifs.sv -----
// valid/ready channel interfaces for requests and responses
`default_nettype none
interface bba_req_if import bba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [REQ_W-1:0]  request_bytes;
   logic [OFF_W-1:0]  block_offset;

   modport source (output valid, func, request_bytes, block_offset, input ready);
   modport sink (input valid, func, request_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [OFF_W-1:0]     granted_offset;
   logic [LVL_OUT_W-1:0] granted_level;

   modport source (output valid, status, granted_offset, granted_level, input ready);
   modport sink (input valid, status, granted_offset, granted_level, output ready);
endinterface
`default_nettype wire

// ----- sv/bba_front.sv -----
// request classifier: size level, offset checks, command build
`default_nettype none
module bba_front import bba_pkg::*; #(
   parameter int MAX_LEVELS   = 11,
   parameter int HEADER_BYTES = 16,
   parameter int LVL_W        = 4,
   parameter int LEAF_W       = 10
) (
   input  wire logic [FUNC_W-1:0] func,
   input  wire logic [REQ_W-1:0]  request_bytes,
   input  wire logic [OFF_W-1:0]  block_offset,
   input  wire logic [CFG_W-1:0]  min_log2,
   input  wire logic [LVL_W-1:0]  top_level,
   output cmd_ctl_type            cmd_ctl,
   output logic [LVL_W-1:0]       cmd_level,
   output logic [LEAF_W-1:0]      cmd_leaf
);

   logic [NEED_W-1:0] need;
   logic [NEED_W-1:0] need_m1;
   logic              fit_found;
   logic [LVL_W-1:0]  fit_level;
   logic              region_bad;
   logic              align_bad;

   // bytes needed including the header
   assign need    = NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES);
   assign need_m1 = need - NEED_W'(1);

   // smallest level whose block holds the need
   always_comb begin
      fit_found = 1'b0;
      fit_level = '0;
      for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
         if ((l <= int'(top_level)) &&
             ((need == '0) || ((need_m1 >> (int'(min_log2) + l)) == '0))) begin
            fit_found = 1'b1;
            fit_level = LVL_W'(l);
         end
      end
   end

   // offset checks for a free
   assign region_bad = (block_offset >> (int'(min_log2) + int'(top_level))) != '0;
   assign align_bad  = (block_offset & ~({OFF_W{1'b1}} << min_log2)) != '0;
   assign cmd_leaf   = LEAF_W'(block_offset >> min_log2);

   // command selection
   always_comb begin
      cmd_ctl.op     = CMD_DONE;
      cmd_ctl.status = ST_OK;
      cmd_level      = fit_level;
      case (func)
         FUNC_ALLOC: begin
            if (fit_found) begin
               cmd_ctl.op = CMD_ALLOC;
            end else begin
               cmd_ctl.status = ST_TOO_LARGE;
            end
         end
         FUNC_FREE: begin
            if (region_bad || align_bad) begin
               cmd_ctl.status = ST_BAD_OFFSET;
            end else begin
               cmd_ctl.op = CMD_FREE;
            end
         end
         FUNC_INIT: begin
            cmd_ctl.op = CMD_INIT;
         end
         default: begin
            cmd_ctl.op = CMD_DONE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/bba_queue.sv -----
// short command queue between front and back
`default_nettype none
module bba_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- sv/bba_back.sv -----
// tree engine: free bit scan, split, merge, leaf tags, clearing pass
`default_nettype none
module bba_back import bba_pkg::*; #(
   parameter int LEAF_BLOCKS = 1024,
   parameter int MAX_LEVELS  = 11,
   parameter int LVL_W       = 4,
   parameter int LEAF_W      = 10,
   parameter int POS_W       = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 init_req,
   input  wire logic                 cmd_valid,
   input  wire cmd_ctl_type          cmd_ctl,
   input  wire logic [LVL_W-1:0]     cmd_level,
   input  wire logic [LEAF_W-1:0]    cmd_leaf,
   input  wire logic [OFF_W-1:0]     cmd_offset,
   input  wire logic [CFG_W-1:0]     min_log2,
   input  wire logic [LVL_W-1:0]     top_level,
   output logic                      cmd_pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [OFF_W-1:0]          rsp_offset,
   output logic [LVL_OUT_W-1:0]      rsp_level
);

   localparam int TREE_NODES = (1 << MAX_LEVELS) - 1;
   localparam int NODE_W     = MAX_LEVELS;
   localparam int CLR_N      = (TREE_NODES > LEAF_BLOCKS) ? TREE_NODES : LEAF_BLOCKS;
   localparam int CLR_W      = $clog2(CLR_N);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_SCAN_RD   = 4'd2;
   localparam logic [3:0] S_SCAN_CHK  = 4'd3;
   localparam logic [3:0] S_SPLIT     = 4'd4;
   localparam logic [3:0] S_LEAF_RD   = 4'd5;
   localparam logic [3:0] S_LEAF_CHK  = 4'd6;
   localparam logic [3:0] S_MERGE_RD  = 4'd7;
   localparam logic [3:0] S_MERGE_CHK = 4'd8;

   // node index of position p at depth d
   function automatic logic [NODE_W-1:0] node_addr(input logic [LVL_W-1:0] d,
                                                   input logic [POS_W-1:0] p);
      logic [31:0] base;
      base = (32'd1 << d) - 32'd1;
      return NODE_W'(base) + NODE_W'(p);
   endfunction

   // storage
   logic                free_mem [TREE_NODES];
   logic                alloc_mem [LEAF_BLOCKS];
   logic [LVL_W-1:0]    level_mem [LEAF_BLOCKS];
   logic                fm_q_ff;
   logic                la_q_ff;
   logic [LVL_W-1:0]    ll_q_ff;

   // sequencer state
   logic [3:0]          st_ff, st_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic                init_rsp_ff, init_rsp_in;
   logic [LVL_W-1:0]    d_ff, d_in;
   logic [LVL_W-1:0]    dtgt_ff, dtgt_in;
   logic [POS_W-1:0]    p_ff, p_in;
   logic [LVL_W-1:0]    lv_ff, lv_in;
   logic [LEAF_W-1:0]   leaf_ff, leaf_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [STAT_W-1:0]   rsp_stat_ff, rsp_stat_in;
   logic [OFF_W-1:0]    rsp_off_ff, rsp_off_in;
   logic [LVL_OUT_W-1:0] rsp_lvl_ff, rsp_lvl_in;

   // memory ports
   logic                fm_we;
   logic [NODE_W-1:0]   fm_waddr;
   logic                fm_wdata;
   logic [NODE_W-1:0]   fm_raddr;
   logic                la_we;
   logic [LEAF_W-1:0]   la_waddr;
   logic                la_wdata;
   logic                ll_we;
   logic [POS_W-1:0]    p_last;
   logic [POS_W-1:0]    p_child;

   assign clearing   = (st_ff == S_CLEAR);
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_offset = rsp_off_ff;
   assign rsp_level  = rsp_lvl_ff;
   assign p_last     = POS_W'((32'd1 << d_ff) - 32'd1);
   assign p_child    = POS_W'({p_ff, 1'b0});

   // sequencer
   always_comb begin
      st_in       = st_ff;
      clr_in      = clr_ff;
      init_rsp_in = init_rsp_ff;
      d_in        = d_ff;
      dtgt_in     = dtgt_ff;
      p_in        = p_ff;
      lv_in       = lv_ff;
      leaf_in     = leaf_ff;
      off_in      = off_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_off_in  = rsp_off_ff;
      rsp_lvl_in  = rsp_lvl_ff;
      cmd_pop     = 1'b0;
      fm_we       = 1'b0;
      fm_waddr    = node_addr(d_ff, p_ff);
      fm_wdata    = 1'b0;
      fm_raddr    = node_addr(d_ff, p_ff);
      la_we       = 1'b0;
      la_waddr    = leaf_ff;
      la_wdata    = 1'b0;
      ll_we       = 1'b0;

      // response beat taken
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end

      case (st_ff)
         S_CLEAR: begin
            if (int'(clr_ff) < TREE_NODES) begin
               fm_we    = 1'b1;
               fm_waddr = NODE_W'(clr_ff);
               fm_wdata = (clr_ff == '0);
            end
            if (int'(clr_ff) < LEAF_BLOCKS) begin
               la_we    = 1'b1;
               la_waddr = LEAF_W'(clr_ff);
            end
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               st_in = S_IDLE;
               if (init_rsp_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_stat_in = ST_OK;
                  rsp_off_in  = '0;
                  rsp_lvl_in  = '0;
               end
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (cmd_valid && !rsp_vld_ff) begin
               cmd_pop = 1'b1;
               lv_in   = cmd_level;
               leaf_in = cmd_leaf;
               off_in  = cmd_offset;
               case (cmd_ctl.op)
                  CMD_ALLOC: begin
                     d_in    = top_level - cmd_level;
                     dtgt_in = top_level - cmd_level;
                     p_in    = '0;
                     st_in   = S_SCAN_RD;
                  end
                  CMD_FREE: begin
                     st_in = S_LEAF_RD;
                  end
                  CMD_INIT: begin
                     clr_in      = '0;
                     init_rsp_in = 1'b1;
                     st_in       = S_CLEAR;
                  end
                  default: begin
                     rsp_vld_in  = 1'b1;
                     rsp_stat_in = cmd_ctl.status;
                     rsp_off_in  = '0;
                     rsp_lvl_in  = '0;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            st_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (fm_q_ff) begin
               // take this block
               fm_we = 1'b1;
               st_in = S_SPLIT;
            end else if (p_ff == p_last) begin
               if (d_ff == '0) begin
                  rsp_vld_in  = 1'b1;
                  rsp_stat_in = ST_NO_MEMORY;
                  rsp_off_in  = '0;
                  rsp_lvl_in  = '0;
                  st_in       = S_IDLE;
               end else begin
                  d_in  = d_ff - 1'b1;
                  p_in  = '0;
                  st_in = S_SCAN_RD;
               end
            end else begin
               p_in  = p_ff + 1'b1;
               st_in = S_SCAN_RD;
            end
         end
         S_SPLIT: begin
            if (d_ff < dtgt_ff) begin
               // keep left half, free right half
               d_in     = d_ff + 1'b1;
               p_in     = p_child;
               fm_we    = 1'b1;
               fm_waddr = node_addr(d_ff + 1'b1, p_child | POS_W'(1));
               fm_wdata = 1'b1;
            end else begin
               la_we       = 1'b1;
               la_waddr    = LEAF_W'(32'(p_ff) << lv_ff);
               la_wdata    = 1'b1;
               ll_we       = 1'b1;
               rsp_vld_in  = 1'b1;
               rsp_stat_in = ST_OK;
               rsp_off_in  = OFF_W'(64'(p_ff) << (int'(min_log2) + int'(lv_ff)));
               rsp_lvl_in  = LVL_OUT_W'(lv_ff);
               st_in       = S_IDLE;
            end
         end
         S_LEAF_RD: begin
            st_in = S_LEAF_CHK;
         end
         S_LEAF_CHK: begin
            if (!la_q_ff || (ll_q_ff > top_level)) begin
               rsp_vld_in  = 1'b1;
               rsp_stat_in = ST_NOT_ALLOC;
               rsp_off_in  = '0;
               rsp_lvl_in  = '0;
               st_in       = S_IDLE;
            end else begin
               la_we = 1'b1;
               lv_in = ll_q_ff;
               p_in  = POS_W'(leaf_ff >> ll_q_ff);
               d_in  = top_level - ll_q_ff;
               st_in = S_MERGE_RD;
            end
         end
         S_MERGE_RD: begin
            fm_raddr = node_addr(d_ff, p_ff ^ POS_W'(1));
            if (d_ff == '0) begin
               fm_we       = 1'b1;
               fm_wdata    = 1'b1;
               rsp_vld_in  = 1'b1;
               rsp_stat_in = ST_OK;
               rsp_off_in  = off_ff;
               rsp_lvl_in  = LVL_OUT_W'(lv_ff);
               st_in       = S_IDLE;
            end else begin
               st_in = S_MERGE_CHK;
            end
         end
         S_MERGE_CHK: begin
            if (fm_q_ff) begin
               // buddy free: absorb it and climb
               fm_we    = 1'b1;
               fm_waddr = node_addr(d_ff, p_ff ^ POS_W'(1));
               p_in     = p_ff >> 1;
               d_in     = d_ff - 1'b1;
               st_in    = S_MERGE_RD;
            end else begin
               fm_we       = 1'b1;
               fm_wdata    = 1'b1;
               rsp_vld_in  = 1'b1;
               rsp_stat_in = ST_OK;
               rsp_off_in  = off_ff;
               rsp_lvl_in  = LVL_OUT_W'(lv_ff);
               st_in       = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      // register write restarts the clearing pass
      if (init_req) begin
         st_in       = S_CLEAR;
         clr_in      = '0;
         init_rsp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_CLEAR;
         clr_ff      <= '0;
         init_rsp_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         st_ff       <= st_in;
         clr_ff      <= clr_in;
         init_rsp_ff <= init_rsp_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      dtgt_ff     <= dtgt_in;
      p_ff        <= p_in;
      lv_ff       <= lv_in;
      leaf_ff     <= leaf_in;
      off_ff      <= off_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_lvl_ff  <= rsp_lvl_in;
   end

   // free bit memory
   always_ff @(posedge clock) begin
      if (fm_we) begin
         free_mem[fm_waddr] <= fm_wdata;
      end
      fm_q_ff <= free_mem[fm_raddr];
   end

   // leaf tag memories
   always_ff @(posedge clock) begin
      if (la_we) begin
         alloc_mem[la_waddr] <= la_wdata;
      end
      la_q_ff <= alloc_mem[leaf_ff];
   end

   always_ff @(posedge clock) begin
      if (ll_we) begin
         level_mem[la_waddr] <= lv_ff;
      end
      ll_q_ff <= level_mem[leaf_ff];
   end

endmodule
`default_nettype wire

// ----- sv/buddy_block_allocator_unit.sv -----
// buddy block allocator top level: registers, front, queue, back
//
//   channel   direction   handshake              beat
//   req       in          valid/ready            func, request_bytes, block_offset
//   rsp       out         valid/ready            status, granted_offset, granted_level
//   apb       in          psel/penable/pready    paddr, pwdata, prdata
//
// allocate: take the command, probe free bits from the block's level upward (a read
//   state then a check state per probe), a split state per split, then post the response beat.
// free: take the command, read then check the leaf tags, then a read and a check per
//   merge; the read posts the response when the block reaches the top, the check when merging stops below it.
// reset, a register write or a reinitialize runs a clearing pass over
//   max(2^MAX_LEVELS - 1, LEAF_BLOCKS) entries during which req.ready is low.
// a waiting response holds the back idle; the queue keeps taking beats meanwhile until it is full.
`default_nettype none
module buddy_block_allocator_unit import bba_pkg::*; #(
   parameter int LEAF_BLOCKS  = 1024,
   parameter int MAX_LEVELS   = 11,
   parameter int HEADER_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   bba_req_if.sink          req,
   bba_rsp_if.source        rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
   localparam int LEAF_W    = $clog2(LEAF_BLOCKS);
   localparam int POS_W     = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
   localparam int LEAF_LOG2 = $clog2(LEAF_BLOCKS + 1) - 1;
   localparam int LVL_CAP   = (MAX_LEVELS < LEAF_LOG2 + 1) ? MAX_LEVELS : LEAF_LOG2 + 1;
   localparam int CTL_W     = $bits(cmd_ctl_type);
   localparam int QW        = CTL_W + LVL_W + LEAF_W + OFF_W;

   logic [CFG_W-1:0] min_ff, min_in;
   logic [CFG_W-1:0] lvls_ff, lvls_in;
   logic             cfg_wr;
   logic [CFG_W-1:0] eff_min;
   logic [LVL_W-1:0] top_level;

   cmd_ctl_type      f_ctl;
   logic [LVL_W-1:0] f_level;
   logic [LEAF_W-1:0] f_leaf;
   logic [QW-1:0]    q_din;
   logic [QW-1:0]    q_dout;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic             clearing;
   cmd_ctl_type      b_ctl;
   logic [LVL_W-1:0] b_level;
   logic [LEAF_W-1:0] b_leaf;
   logic [OFF_W-1:0] b_offset;

   // register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_LEVELS) ? 32'(lvls_ff) : 32'(min_ff);

   always_comb begin
      min_in  = min_ff;
      lvls_in = lvls_ff;
      if (cfg_wr) begin
         case (paddr[2])
            REG_MIN_LOG2: min_in  = pwdata[CFG_W-1:0];
            REG_LEVELS:   lvls_in = pwdata[CFG_W-1:0];
            default:      min_in  = min_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= MIN_LOG2_RST;
         lvls_ff <= LEVELS_RST;
      end else begin
         min_ff  <= min_in;
         lvls_ff <= lvls_in;
      end
   end

   // effective block size and level count
   assign eff_min = (min_ff < MIN_LOG2_LO) ? MIN_LOG2_LO :
                    (min_ff > MIN_LOG2_HI) ? MIN_LOG2_HI : min_ff;

   always_comb begin
      if (lvls_ff == '0) begin
         top_level = '0;
      end else if (int'(lvls_ff) > LVL_CAP) begin
         top_level = LVL_W'(LVL_CAP - 1);
      end else begin
         top_level = LVL_W'(int'(lvls_ff) - 1);
      end
   end

   // front: classify the request beat
   bba_front #(
      .MAX_LEVELS   (MAX_LEVELS),
      .HEADER_BYTES (HEADER_BYTES),
      .LVL_W        (LVL_W),
      .LEAF_W       (LEAF_W)
   ) u_front (
      .func          (req.func),
      .request_bytes (req.request_bytes),
      .block_offset  (req.block_offset),
      .min_log2      (eff_min),
      .top_level     (top_level),
      .cmd_ctl       (f_ctl),
      .cmd_level     (f_level),
      .cmd_leaf      (f_leaf)
   );

   assign req.ready = !q_full && !clearing;
   assign q_din     = {f_ctl, f_level, f_leaf, req.block_offset};

   // command queue
   bba_queue #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req.valid && req.ready),
      .push_data (q_din),
      .pop       (q_pop),
      .pop_data  (q_dout),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {b_ctl, b_level, b_leaf, b_offset} = q_dout;

   // back: tree operations
   bba_back #(
      .LEAF_BLOCKS (LEAF_BLOCKS),
      .MAX_LEVELS  (MAX_LEVELS),
      .LVL_W       (LVL_W),
      .LEAF_W      (LEAF_W),
      .POS_W       (POS_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .init_req   (cfg_wr),
      .cmd_valid  (!q_empty),
      .cmd_ctl    (b_ctl),
      .cmd_level  (b_level),
      .cmd_leaf   (b_leaf),
      .cmd_offset (b_offset),
      .min_log2   (eff_min),
      .top_level  (top_level),
      .cmd_pop    (q_pop),
      .clearing   (clearing),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_status (rsp.status),
      .rsp_offset (rsp.granted_offset),
      .rsp_level  (rsp.granted_level)
   );

endmodule
`default_nettype wire

// ----- sv/bba_checker.sv -----
// port-level checks for the buddy block allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bba_checker import bba_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [STAT_W-1:0]    rsp_status,
   input wire logic [OFF_W-1:0]     rsp_offset,
   input wire logic [LVL_OUT_W-1:0] rsp_level
);

   // no beat leaves right after reset
   `BBA_ASSERT_RST(a_no_rsp_after_reset, reset |=> !rsp_valid, "response right after reset")

   // clearing pass blocks requests after reset
   `BBA_ASSERT_RST(a_clear_after_reset, reset |=> !req_ready, "request taken during clearing")

   // failed requests report zero offset and level
   `BBA_ASSERT(a_err_zero, (rsp_valid && rsp_status != ST_OK) |-> (rsp_offset == '0 && rsp_level == '0), "error beat carries data")

   // stalled response holds
   `BBA_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_offset)), "stalled response changed")

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status),
   .rsp_offset (rsp.granted_offset),
   .rsp_level  (rsp.granted_level)
);
`default_nettype wire
